### sv/tvnc_pkg.sv
// package: type codes, payload types and conversion functions
package tvnc_pkg;

    localparam int unsigned WordW = 64;

    typedef enum logic [3:0] {
        TAG_I8   = 4'd0,
        TAG_U8   = 4'd1,
        TAG_I16  = 4'd2,
        TAG_U16  = 4'd3,
        TAG_I32  = 4'd4,
        TAG_U32  = 4'd5,
        TAG_I64  = 4'd6,
        TAG_U64  = 4'd7,
        TAG_F32  = 4'd8,
        TAG_F64  = 4'd9,
        TAG_BOOL = 4'd10,
        TAG_CHAR = 4'd11
    } tag_t;

    localparam logic ACT_INT   = 1'b0;
    localparam logic ACT_FLOAT = 1'b1;

    typedef struct packed {
        logic        action;
        logic [3:0]  type_tag;
        logic [63:0] payload;
    } in_word_t;

    typedef struct packed {
        logic [63:0] converted;
        logic        invalid;
    } out_word_t;

    // position of leading one, 64-bit input, zero gives zero
    function automatic logic [5:0] lead_one(input logic [63:0] v);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) p = 6'(i);
        end
        return p;
    endfunction

    // exact widening of binary32 to binary64
    function automatic logic [63:0] widen_f32(input logic [31:0] f);
        logic [7:0]  e;
        logic [22:0] m;
        logic [4:0]  k;
        logic [63:0] o;
        logic [63:0] sh;
        e = f[30:23];
        m = f[22:0];
        o = {f[31], 63'd0};
        k = 5'd0;
        sh = '0;
        if (e == 8'hFF) begin
            o[62:52] = 11'h7FF;
            if (m != 23'd0) o[51:0] = {1'b1, m[21:0], 29'd0};
        end else if (e == 8'd0) begin
            if (m != 23'd0) begin
                k = 5'(lead_one({41'd0, m}));
                o[62:52] = 11'(k) + 11'd874;
                sh = {41'd0, m} << (6'd52 - 6'(k));
                o[51:0] = sh[51:0];
            end
        end else begin
            o[62:52] = {3'd0, e} + 11'd896;
            o[51:0] = {m, 29'd0};
        end
        return o;
    endfunction

    // binary64 to i64 truncating, saturating, flag in bit 64
    function automatic logic [64:0] f64_to_i64(input logic [63:0] b);
        logic [10:0]  e;
        logic [51:0]  m;
        logic [10:0]  ex;
        logic [63:0]  sig;
        logic [63:0]  mag;
        e = b[62:52];
        m = b[51:0];
        ex = e - 11'd1023;
        sig = {11'd0, 1'b1, m};
        mag = '0;
        if (e == 11'h7FF && m != 52'd0) return {1'b1, 64'd0};
        if (e < 11'd1023) return 65'd0;
        if (ex >= 11'd63) begin
            if (b[63] && ex == 11'd63 && m == 52'd0) return {1'b0, 1'b1, 63'd0};
            return b[63] ? {1'b1, 1'b1, 63'd0} : {1'b1, 1'b0, {63{1'b1}}};
        end
        if (ex >= 11'd52) mag = sig << (ex[5:0] - 6'd52);
        else mag = sig >> (6'd52 - ex[5:0]);
        return {1'b0, b[63] ? (64'd0 - mag) : mag};
    endfunction

    // sign and magnitude to binary64, nearest even
    function automatic logic [63:0] mag_to_f64(input logic s, input logic [63:0] mag);
        logic [5:0]  p;
        logic [5:0]  sh;
        logic [63:0] mk;
        logic [63:0] rem;
        logic [63:0] half;
        logic [53:0] mant;
        logic [10:0] ex;
        if (mag == 64'd0) return 64'd0;
        p = lead_one(mag);
        sh = '0;
        mk = '0;
        if (p <= 6'd52) begin
            mk = mag << (6'd52 - p);
            mant = mk[53:0];
            ex = 11'(p) + 11'd1023;
        end else begin
            sh = p - 6'd52;
            rem = mag & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 6'd1);
            mk = mag >> sh;
            mant = mk[53:0];
            if (rem > half || (rem == half && mant[0])) mant = mant + 54'd1;
            ex = 11'(p) + 11'd1023;
            if (mant[53]) ex = ex + 11'd1;
        end
        return {s, ex, mant[51:0]};
    endfunction

endpackage

### sv/tvnc_if.sv
// valid/ready channel interface carrying one word
interface tvnc_if #(parameter type word_t = logic) ();
    logic  valid;
    logic  ready;
    word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/tvnc_datapath.sv
// combinational conversion of one registered word
module tvnc_datapath (
    input  tvnc_pkg::in_word_t  in_word,
    output tvnc_pkg::out_word_t out_word
);
    logic [63:0] p;
    logic [63:0] ibits;
    logic [63:0] fsrc;
    logic [64:0] f2i;

    assign p = in_word.payload;

    always_comb
    begin
        case (in_word.type_tag)
            tvnc_pkg::TAG_I8:   ibits = {{56{p[7]}}, p[7:0]};
            tvnc_pkg::TAG_U8,
            tvnc_pkg::TAG_CHAR: ibits = {56'd0, p[7:0]};
            tvnc_pkg::TAG_I16:  ibits = {{48{p[15]}}, p[15:0]};
            tvnc_pkg::TAG_U16:  ibits = {48'd0, p[15:0]};
            tvnc_pkg::TAG_I32:  ibits = {{32{p[31]}}, p[31:0]};
            tvnc_pkg::TAG_U32:  ibits = {32'd0, p[31:0]};
            tvnc_pkg::TAG_BOOL: ibits = {63'd0, p[7:0] != 8'd0};
            default:            ibits = p;
        endcase
    end

    assign fsrc = (in_word.type_tag == tvnc_pkg::TAG_F32) ? tvnc_pkg::widen_f32(p[31:0]) : p;
    assign f2i  = tvnc_pkg::f64_to_i64(fsrc);

    always_comb
    begin
        out_word = '0;
        if (in_word.type_tag < 4'd12) begin
            if (in_word.action == tvnc_pkg::ACT_INT) begin
                if (in_word.type_tag == tvnc_pkg::TAG_F32 ||
                    in_word.type_tag == tvnc_pkg::TAG_F64) begin
                    out_word.converted = f2i[63:0];
                    out_word.invalid   = f2i[64];
                end else begin
                    out_word.converted = ibits;
                end
            end else if (in_word.type_tag == tvnc_pkg::TAG_F32 ||
                         in_word.type_tag == tvnc_pkg::TAG_F64) begin
                out_word.converted = fsrc;
            end else if (in_word.type_tag == tvnc_pkg::TAG_U64) begin
                out_word.converted = tvnc_pkg::mag_to_f64(1'b0, p);
            end else begin
                out_word.converted = tvnc_pkg::mag_to_f64(ibits[63],
                    ibits[63] ? (64'd0 - ibits) : ibits);
            end
        end
    end
endmodule

### sv/tagged_value_numeric_converter_core.sv
// top level: tagged scalar to i64 or binary64 converter
//
// channel  dir  word
// in_ch    in   action, type_tag, payload
// out_ch   out  converted, invalid
//
// one word a cycle while the result is not stalled; from acceptance to result a word
// passes the input register, conversion logic and result register
// reset clears both valid flags only
// a stalled result holds; the input register still takes a word when it is empty
// or the result register is free or being drained this cycle
module tagged_value_numeric_converter_core (
    input  logic clk,
    input  logic rst_n,
    tvnc_if.sink   in_ch,
    tvnc_if.source out_ch
);
    tvnc_pkg::in_word_t  in_reg;
    tvnc_pkg::out_word_t res_reg;
    tvnc_pkg::out_word_t res_next;
    logic in_valid_reg;
    logic res_valid_reg;
    logic advance;

    // result register free or draining
    assign advance     = !res_valid_reg || out_ch.ready;
    // input stage takes a word when empty or whenever its word can go forward
    assign in_ch.ready = !in_valid_reg || advance;

    tvnc_datapath u_dp (
        .in_word  (in_reg),
        .out_word (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (in_ch.ready) in_valid_reg <= in_ch.valid;
            if (advance) res_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid) in_reg <= in_ch.data;
        if (advance && in_valid_reg) res_reg <= res_next;
    end

    assign out_ch.valid = res_valid_reg;
    assign out_ch.data  = res_reg;

    // a stalled result holds its word
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !out_ch.ready |=> res_valid_reg && $stable(res_reg))
        else $error("result changed under stall");
    // invalid only on integer target
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && in_reg.action == tvnc_pkg::ACT_FLOAT |-> !res_next.invalid)
        else $error("invalid raised on float target");
    // accepted word reaches the result register when not stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready ##1 advance |=> res_valid_reg)
        else $error("word lost in pipeline");
endmodule
